>>> rtl/core/linear_probe_hash_insert_defines.svh
// Assertion macros for the linear probe hash insert block.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef LINEAR_PROBE_HASH_INSERT_DEFINES_SVH
`define LINEAR_PROBE_HASH_INSERT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LPHI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lphi assertion failed");
// Next-cycle implication.
`define LPHI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lphi assertion failed");
`else
`define LPHI_ASSERT_IMP(lbl, ante, cons)
`define LPHI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/lphi_pkg.sv
// Shared types and constants for the linear probe hash insert block.
// No dependencies.
package lphi_pkg;

  localparam int KEY_W          = 31;
  localparam int VALUE_W        = 32;
  localparam int SLOT_W         = 5;
  localparam int TABLE_SIZE_DEF = 32;

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_REPLACED = 2'd1,
    ST_FULL     = 2'd2
  } lphi_status_e;

  typedef struct packed {
    logic        [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } lphi_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    lphi_status_e      status;
  } lphi_out_t;

endpackage

>>> rtl/core/lphi_mod.sv
// Remainder unit (depends on lphi_pkg): key modulo TABLE_SIZE by reciprocal multiplication,
// multiply back, subtract; registers key, quotient, remainder; done_o pulses: rem_o ready.
module lphi_mod import lphi_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int IW         = $clog2(TABLE_SIZE)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [IW-1:0]    rem_o
);

  localparam int MW = KEY_W + 1;
  localparam int PW = KEY_W + MW;
  localparam int SH = KEY_W + IW;
  // ceil(2^SH / TABLE_SIZE) gives an exact quotient for every key below 2^KEY_W
  localparam logic [63:0] MUL_FULL =
    ((64'd1 << SH) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [MW-1:0]    MUL = MUL_FULL[MW-1:0];
  localparam logic [KEY_W-1:0] DIV = KEY_W'(TABLE_SIZE);

  logic             mul_q;
  logic             sub_q;
  logic             done_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] quo_q;
  logic [IW-1:0]    rem_q;

  logic [PW-1:0]    prod;
  logic [PW-1:0]    prod_sh;
  logic [KEY_W-1:0] quo_d;
  logic [KEY_W-1:0] back;
  logic [KEY_W-1:0] rem_full;

  assign prod     = PW'(key_q) * PW'(MUL);
  assign prod_sh  = prod >> SH;
  assign quo_d    = prod_sh[KEY_W-1:0];
  assign back     = quo_q * DIV;
  assign rem_full = key_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (mul_q) begin
      quo_q <= quo_d;
    end
    if (sub_q) begin
      rem_q <= rem_full[IW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/linear_probe_hash_insert.sv
// Open-addressing hash table insert with linear probing.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one key and value
//   word. Output channel (out_valid_o / out_stall_i / out_data_o) returns one
//   word per input: the slot used and a status of new, replaced or full.
//   A full table drops the item and reports the last slot probed.
// Flow: after accept, the home slot comes from a remainder unit, reciprocal
//   multiply then multiply back and subtract; probing then reads one table row
//   per cycle and covers 1 to TABLE_SIZE slots before the word goes out.
// Throughput: one item at a time, so in_stall_o is low only while idle.
// Reset: a clearing pass writes every row empty, with in_stall_o high until
//   it ends.
// Stall: a finished word waits in the output register while out_stall_i is
//   high; the next item may be accepted meanwhile, and its result is held
//   back until the output register frees.
// Depends on lphi_pkg, lphi_mod and linear_probe_hash_insert_defines.svh.
`include "linear_probe_hash_insert_defines.svh"

module linear_probe_hash_insert import lphi_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lphi_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lphi_out_t out_data_o
);

  localparam int IW   = $clog2(TABLE_SIZE);
  localparam int CNTW = $clog2(TABLE_SIZE + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                      occ;
    logic        [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } row_t;

  state_e state_q;
  logic [IW-1:0]         clr_q;
  logic [KEY_W-1:0]      key_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [IW-1:0]         pos_q;
  logic [CNTW-1:0]       cnt_q;
  lphi_out_t             res_q;
  logic                  out_valid_q;
  lphi_out_t             out_q;

  row_t          mem_q [TABLE_SIZE];
  row_t          rd_q;
  logic          we;
  logic [IW-1:0] wa;
  row_t          wd;
  logic [IW-1:0] ra;

  logic          in_acc;
  logic          out_free;
  logic          mod_done;
  logic [IW-1:0] mod_rem;
  logic          hit_empty;
  logic          hit_same;
  logic          last_probe;
  logic [IW-1:0] pos_nxt;
  logic [IW+SLOT_W-1:0] pos_ext;

  assign in_acc   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  lphi_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .IW         (IW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .key_i   (in_data_i.key),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign hit_empty  = !rd_q.occ;
  assign hit_same   = rd_q.occ && (rd_q.key == key_q);
  assign last_probe = (cnt_q == CNTW'(TABLE_SIZE - 1));
  assign pos_nxt    = (pos_q == IW'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;
  assign pos_ext    = (IW+SLOT_W)'(pos_q);

  // Table port control: clear sweep, probe write, home-row read in S_MOD, next-row read.
  always_comb begin
    we = 1'b0;
    wa = pos_q;
    wd = '{occ: 1'b1, key: key_q, value: value_q};
    ra = pos_nxt;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
      wa = clr_q;
      wd = '{occ: 1'b0, key: '0, value: '0};
    end else if (state_q == S_PROBE) begin
      we = hit_empty || hit_same;
    end else if (state_q == S_MOD) begin
      ra = mod_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IW'(TABLE_SIZE - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (hit_empty || hit_same || last_probe) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item and result words, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q   <= in_data_i.key;
      value_q <= in_data_i.value;
    end
    if (state_q == S_MOD && mod_done) begin
      pos_q <= mod_rem;
      cnt_q <= '0;
    end else if (state_q == S_PROBE) begin
      pos_q <= pos_nxt;
      cnt_q <= cnt_q + 1'b1;
      res_q.slot <= pos_ext[SLOT_W-1:0];
      if (hit_empty) begin
        res_q.status <= ST_NEW;
      end else if (hit_same) begin
        res_q.status <= ST_REPLACED;
      end else begin
        res_q.status <= ST_FULL;
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPHI_ASSERT_IMP(a_cnt_in_range, state_q == S_PROBE, cnt_q < CNTW'(TABLE_SIZE))
  `LPHI_ASSERT_IMP(a_rem_in_range, mod_done, mod_rem <= IW'(TABLE_SIZE - 1))
  `LPHI_ASSERT_IMP(a_no_out_in_clear, state_q == S_CLEAR, !out_valid_q)
  `LPHI_ASSERT_NEXT(a_done_fills_out, state_q == S_DONE && out_free, out_valid_q && state_q == S_IDLE)

endmodule
